/* rtl/core/msot_pkg.sv */
// ----------------------------------------------------------------------------
// msot_pkg
// Shared types and constants for the one-shot timer pool.
// ----------------------------------------------------------------------------
`default_nettype none

package msot_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int TAG_W     = 8;
	localparam int DUR_W     = 32;
	localparam int ELA_W     = 16;
	localparam int ACT_W     = 5;

	typedef enum logic [1:0] {
		ST_ADDED = 2'd0,
		ST_FULL  = 2'd1,
		ST_FIRED = 2'd2,
		ST_IDLE  = 2'd3
	} status_t;

	typedef enum logic {
		FN_ADD  = 1'b0,
		FN_TICK = 1'b1
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [TAG_W-1:0]   tag;
		logic [DUR_W-1:0]   dur;
		logic [ELA_W-1:0]   ela;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ADD,
		BK_RD,
		BK_EVAL,
		BK_FIN
	} bk_state_t;

endpackage

`default_nettype wire

/* rtl/core/msot_ifs.sv */
// ----------------------------------------------------------------------------
// msot_ifs
// Request and response channels of the timer pool (valid/ready).
// ----------------------------------------------------------------------------
`default_nettype none

interface msot_req_if;
	import msot_pkg::*;

	logic               valid;
	logic               ready;
	logic               func;
	logic [TAG_W-1:0]   event_tag;
	logic [DUR_W-1:0]   duration_ms;
	logic [ELA_W-1:0]   tick_ms;

	modport source (output valid, func, event_tag, duration_ms, tick_ms, input ready);
	modport sink   (input valid, func, event_tag, duration_ms, tick_ms, output ready);
endinterface

interface msot_rsp_if;
	import msot_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [TAG_W-1:0]   fired_tag;
	logic [ACT_W-1:0]   active_count;
	logic               last;

	modport source (output valid, status, fired_tag, active_count, last, input ready);
	modport sink   (input valid, status, fired_tag, active_count, last, output ready);
endinterface

`default_nettype wire

/* rtl/core/msot_ram.sv */
// ----------------------------------------------------------------------------
// msot_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msot_ram #(
	parameter int W = 8,
	parameter int D = 16,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/msot_front.sv */
// ----------------------------------------------------------------------------
// msot_front
// Accepts request transfers, classifies them as add or tick and queues them
// for the slot engine in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module msot_front (
	input  wire logic     clk,
	input  wire logic     arst_n,
	msot_req_if.sink      req,
	output msot_pkg::cmd_t cmd,
	output logic          cmd_valid,
	input  wire logic     cmd_pop
);
	import msot_pkg::*;

	localparam int QD = 2;

	cmd_t       q_q [QD];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	cmd_t       cls;

	assign req.ready = (cnt_q != 2'(QD));
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rp_q];
	assign push      = req.valid & req.ready;
	assign pop       = cmd_pop & cmd_valid;

	// unused fields are zeroed per kind
	always_comb begin
		cls = '0;
		if (req.func == FN_TICK) begin
			cls.func = FN_TICK;
			cls.ela  = req.tick_ms;
		end else begin
			cls.func = FN_ADD;
			cls.tag  = req.event_tag;
			cls.dur  = req.duration_ms;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/msot_back.sv */
// ----------------------------------------------------------------------------
// msot_back
// Slot engine: walks the slots one per step for adds and ticks, keeps the
// valid bits and occupancy count, and drives the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module msot_back #(
	parameter int SLOTS = msot_pkg::SLOTS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire msot_pkg::cmd_t cmd,
	input  wire logic           cmd_valid,
	output logic                cmd_pop,
	msot_rsp_if.source          rsp
);
	import msot_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int RW    = DUR_W + TAG_W;

	bk_state_t          state_q, state_d;
	cmd_t               cmd_q;
	logic [IDX_W-1:0]   idx_q;
	logic [SLOTS-1:0]   valid_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               held_q;
	logic [TAG_W-1:0]   held_tag_q;
	logic [CNT_W-1:0]   held_cnt_q;

	logic               ov_q;
	status_t            ost_q;
	logic [TAG_W-1:0]   otag_q;
	logic [CNT_W-1:0]   ocnt_q;
	logic               olast_q;

	logic               out_free;
	logic               idx_last;
	logic               slot_free;
	logic               eval_go;

	logic               we, re;
	logic [RW-1:0]      wdata, rdata;
	logic [DUR_W-1:0]   rd_rem, new_rem, ela_x;
	logic [TAG_W-1:0]   rd_tag;

	logic               emit;
	status_t            e_st;
	logic [TAG_W-1:0]   e_tag;
	logic [CNT_W-1:0]   e_cnt;
	logic               e_last;
	logic               set_v, clr_v, idx_inc, hold_ld, hold_clr;
	logic [CNT_W+ACT_W-1:0] act_ext;

	msot_ram #(.W(RW), .D(SLOTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (idx_q),
		.wdata (wdata),
		.re    (re),
		.raddr (idx_q),
		.rdata (rdata)
	);

	assign out_free  = ~ov_q | rsp.ready;
	assign idx_last  = (idx_q == IDX_W'(SLOTS - 1));
	assign slot_free = ~valid_q[idx_q];
	assign rd_rem    = rdata[RW-1:TAG_W];
	assign rd_tag    = rdata[TAG_W-1:0];
	assign ela_x     = DUR_W'(cmd_q.ela);
	assign new_rem   = (ela_x >= rd_rem) ? '0 : (rd_rem - ela_x);
	assign eval_go   = (rd_rem != '0) | ~held_q | out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					state_d = (cmd.func == FN_TICK) ? BK_RD : BK_ADD;
				end
			end
			BK_ADD: begin
				if (out_free && (slot_free || idx_last)) begin
					state_d = BK_IDLE;
				end
			end
			BK_RD: begin
				if (!slot_free) begin
					state_d = BK_EVAL;
				end else if (idx_last) begin
					state_d = BK_FIN;
				end
			end
			BK_EVAL: begin
				if (eval_go) begin
					state_d = idx_last ? BK_FIN : BK_RD;
				end
			end
			BK_FIN: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop  = 1'b0;
		emit     = 1'b0;
		e_st     = ST_IDLE;
		e_tag    = '0;
		e_cnt    = cnt_q;
		e_last   = 1'b1;
		we       = 1'b0;
		re       = 1'b0;
		wdata    = {cmd_q.dur, cmd_q.tag};
		set_v    = 1'b0;
		clr_v    = 1'b0;
		idx_inc  = 1'b0;
		hold_ld  = 1'b0;
		hold_clr = 1'b0;
		case (state_q)
			BK_IDLE: begin
				cmd_pop = cmd_valid;
			end
			BK_ADD: begin
				if (slot_free) begin
					if (out_free) begin
						we    = 1'b1;
						set_v = 1'b1;
						emit  = 1'b1;
						e_st  = ST_ADDED;
						e_cnt = CNT_W'(cnt_q + 1'b1);
					end
				end else if (idx_last) begin
					if (out_free) begin
						emit = 1'b1;
						e_st = ST_FULL;
					end
				end else begin
					idx_inc = 1'b1;
				end
			end
			BK_RD: begin
				if (!slot_free) begin
					re = 1'b1;
				end else if (!idx_last) begin
					idx_inc = 1'b1;
				end
			end
			BK_EVAL: begin
				if (rd_rem == '0) begin
					if (eval_go) begin
						// previous fire goes out now, this one is held
						emit    = held_q;
						e_st    = ST_FIRED;
						e_tag   = held_tag_q;
						e_cnt   = held_cnt_q;
						e_last  = 1'b0;
						clr_v   = 1'b1;
						hold_ld = 1'b1;
					end
				end else begin
					we    = 1'b1;
					wdata = {new_rem, rd_tag};
				end
				if (eval_go && !idx_last) begin
					idx_inc = 1'b1;
				end
			end
			BK_FIN: begin
				if (out_free) begin
					emit     = 1'b1;
					hold_clr = 1'b1;
					if (held_q) begin
						e_st  = ST_FIRED;
						e_tag = held_tag_q;
						e_cnt = held_cnt_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (hold_ld) begin
			held_tag_q <= rd_tag;
			held_cnt_q <= CNT_W'(cnt_q - 1'b1);
		end
		if (emit) begin
			ost_q   <= e_st;
			otag_q  <= e_tag;
			ocnt_q  <= e_cnt;
			olast_q <= e_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q   <= '0;
			valid_q <= '0;
			cnt_q   <= '0;
			held_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_pop) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= IDX_W'(idx_q + 1'b1);
			end
			if (set_v) begin
				valid_q[idx_q] <= 1'b1;
				cnt_q          <= CNT_W'(cnt_q + 1'b1);
			end else if (clr_v) begin
				valid_q[idx_q] <= 1'b0;
				cnt_q          <= CNT_W'(cnt_q - 1'b1);
			end
			if (hold_ld) begin
				held_q <= 1'b1;
			end else if (hold_clr) begin
				held_q <= 1'b0;
			end
			ov_q <= emit | (ov_q & ~rsp.ready);
		end
	end

	assign act_ext          = {{ACT_W{1'b0}}, ocnt_q};
	assign rsp.valid        = ov_q;
	assign rsp.status       = ost_q;
	assign rsp.fired_tag    = otag_q;
	assign rsp.active_count = act_ext[ACT_W-1:0];
	assign rsp.last         = olast_q;

endmodule

`default_nettype wire

/* rtl/core/multi_slot_oneshot_timer.sv */
// ----------------------------------------------------------------------------
// multi_slot_oneshot_timer
// Pool of SLOTS one-shot millisecond timers.
//
// req carries add (func 0: event_tag, duration_ms) and tick (func 1:
// tick_ms) transfers; rsp returns status, fired_tag, active_count, last.
// An add answers once (added or full); a tick answers once per fired slot in
// ascending slot order, or once with idle, the final answer flagged by last.
// Requests pass through a two-entry queue, so the sender can run ahead while
// the slot engine works.
// An add walks the slots up to the lowest free slot, or to the last slot when
// all are occupied; a tick walks every slot, with one read of the slot RAM per
// occupied slot. The engine takes the next request only once it is idle again.
// A result is formed combinationally and captured in the response register; a
// stalled receiver holds the engine only when a new result is due.
// Reset clears the queue, all valid bits and the count at once; slot
// contents need no clearing, so requests are taken as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_slot_oneshot_timer #(
	parameter int SLOTS = msot_pkg::SLOTS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	msot_req_if.sink   req,
	msot_rsp_if.source rsp
);
	import msot_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;

	msot_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop)
	);

	msot_back #(.SLOTS(SLOTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
